>>> hdl/aabb_sweep_velocity_resolver_top_macros.svh
// Assertion macros shared by the collision response block
`ifndef AABB_SWEEP_VELOCITY_RESOLVER_TOP_MACROS_SVH
`define AABB_SWEEP_VELOCITY_RESOLVER_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every rising clk_i edge outside reset
`define ASVR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("asvr assertion failed");

// Check that a condition never holds on a rising clk_i edge outside reset
`define ASVR_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("asvr forbidden condition seen");

`else

`define ASVR_ASSERT(lbl, prop)

`define ASVR_NEVER(lbl, expr)

`endif

`endif

>>> hdl/asvr_pkg.sv
// Types, widths and controller/datapath signal groups of the collision response block
package asvr_pkg;

  localparam int unsigned PosW  = 24;
  localparam int unsigned SizeW = 22;
  localparam int unsigned VelW  = 16;
  // Headroom for position plus velocity plus size without overflow
  localparam int unsigned OvlW  = 27;

  typedef logic signed [PosW-1:0]  pos_t;
  typedef logic        [SizeW-1:0] size_t;
  typedef logic signed [VelW-1:0]  vel_t;
  typedef logic signed [OvlW-1:0]  ovl_t;
  typedef logic        [1:0]       shamt_t;

  localparam shamt_t ShiftFirst = 2'd1;
  localparam shamt_t ShiftLast  = 2'd3;

  typedef enum logic [0:0] {
    OP_LOAD_MOVER = 1'b0,
    OP_NEIGHBOUR  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_XTEST,
    ST_XRETEST,
    ST_YTEST,
    ST_YRETEST,
    ST_FINISH
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic   capture;     // take the input transfer into the item registers
    logic   load_mover;  // copy item registers into the mover registers
    logic   use_y;       // add Y velocities in the overlap test
    logic   set_hit;     // mark the item as a collision report
    logic   shrink_x;    // shift both X velocities right by shamt
    logic   shrink_y;    // shift both Y velocities right by shamt
    logic   zero_x;      // give up the X axis
    logic   zero_y;      // give up the Y axis
    shamt_t shamt;
    logic   out_load;    // write the result register and commit velocities
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic op;
    logic active;
    logic solid_both;
    logic ex_x;
    logic ex_y;
    logic ovl;
    logic out_free;
  } ctrl_sts_t;

endpackage

>>> hdl/asvr_ctrl.sv
// Sequencer for the per-axis test and shrink steps
`include "aabb_sweep_velocity_resolver_top_macros.svh"

module asvr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  asvr_pkg::ctrl_sts_t sts_i,
  output asvr_pkg::ctrl_cmd_t cmd_o
);
  import asvr_pkg::*;

  state_e state_q, state_d;
  shamt_t k_q, k_d;

  // State and shift step registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        cmd_o.use_y = 1'b1;
        if (sts_i.op == OP_LOAD_MOVER) begin
          cmd_o.load_mover = 1'b1;
          state_d          = ST_FINISH;
        end else if (!sts_i.active) begin
          state_d = ST_FINISH;
        end else if (!sts_i.solid_both) begin
          // report only: one test at the predicted positions
          cmd_o.set_hit = sts_i.ovl;
          state_d       = ST_FINISH;
        end else begin
          state_d = ST_XTEST;
        end
      end
      ST_XTEST: begin
        if (sts_i.ex_x || !sts_i.ovl) begin
          state_d = ST_YTEST;
        end else begin
          cmd_o.set_hit  = 1'b1;
          cmd_o.shrink_x = 1'b1;
          cmd_o.shamt    = ShiftFirst;
          k_d            = ShiftFirst;
          state_d        = ST_XRETEST;
        end
      end
      ST_XRETEST: begin
        if (!sts_i.ovl) begin
          state_d = ST_YTEST;
        end else if (k_q == ShiftLast) begin
          cmd_o.zero_x = 1'b1;
          state_d      = ST_YTEST;
        end else begin
          cmd_o.shrink_x = 1'b1;
          cmd_o.shamt    = k_q + 2'd1;
          k_d            = k_q + 2'd1;
        end
      end
      ST_YTEST: begin
        cmd_o.use_y = 1'b1;
        if (sts_i.ex_y || !sts_i.ovl) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.set_hit  = 1'b1;
          cmd_o.shrink_y = 1'b1;
          cmd_o.shamt    = ShiftFirst;
          k_d            = ShiftFirst;
          state_d        = ST_YRETEST;
        end
      end
      ST_YRETEST: begin
        cmd_o.use_y = 1'b1;
        if (!sts_i.ovl) begin
          state_d = ST_FINISH;
        end else if (k_q == ShiftLast) begin
          cmd_o.zero_y = 1'b1;
          state_d      = ST_FINISH;
        end else begin
          cmd_o.shrink_y = 1'b1;
          cmd_o.shamt    = k_q + 2'd1;
          k_d            = k_q + 2'd1;
        end
      end
      ST_FINISH: begin
        // hold until the result register can take the transfer
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `ASVR_ASSERT(a_axis_cmd_excl, ($onehot0({cmd_o.shrink_x, cmd_o.shrink_y, cmd_o.zero_x, cmd_o.zero_y})))
  `ASVR_NEVER(a_retest_step_set, ((state_q == ST_XRETEST || state_q == ST_YRETEST) && k_q == 2'd0))
  `ASVR_ASSERT(a_capture_dispatch, (cmd_o.capture |=> state_q == ST_DISPATCH))

endmodule

>>> hdl/asvr_dp.sv
// Box registers, shared overlap comparator, velocity shifters and result register
`include "aabb_sweep_velocity_resolver_top_macros.svh"

module asvr_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  asvr_pkg::ctrl_cmd_t cmd_i,
  output asvr_pkg::ctrl_sts_t sts_o,
  input  logic                op_i,
  input  asvr_pkg::pos_t      pos_x_i,
  input  asvr_pkg::pos_t      pos_y_i,
  input  asvr_pkg::size_t     size_w_i,
  input  asvr_pkg::size_t     size_h_i,
  input  asvr_pkg::vel_t      vel_x_i,
  input  asvr_pkg::vel_t      vel_y_i,
  input  logic                solid_i,
  input  logic                last_neighbour_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                hit_o,
  output asvr_pkg::vel_t      mover_vel_x_o,
  output asvr_pkg::vel_t      mover_vel_y_o,
  output logic                done_res_o
);
  import asvr_pkg::*;

  // Item registers
  logic  n_op_q, n_solid_q, n_last_q;
  pos_t  n_x_q, n_y_q;
  size_t n_w_q, n_h_q;
  vel_t  n_vx_q, n_vy_q;

  // Mover registers
  pos_t  m_x_q, m_y_q;
  size_t m_w_q, m_h_q;
  logic  m_solid_q, m_active_q;
  vel_t  run_vx_q, run_vy_q;

  // Working velocities of mover and neighbour
  vel_t  vx_w_q, vy_w_q, pvx_w_q, pvy_w_q;
  logic  hit_q;

  // Result register
  logic  out_valid_q, out_hit_q, out_done_q;
  vel_t  out_vx_q, out_vy_q;

  ovl_t  ax, ay, bx, by, mw, mh, nw, nh;
  logic  last_item;

  assign last_item = (n_op_q == OP_NEIGHBOUR) && n_last_q;

  // Item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      n_op_q    <= op_i;
      n_x_q     <= pos_x_i;
      n_y_q     <= pos_y_i;
      n_w_q     <= size_w_i;
      n_h_q     <= size_h_i;
      n_vx_q    <= vel_x_i;
      n_vy_q    <= vel_y_i;
      n_solid_q <= solid_i;
      n_last_q  <= last_neighbour_i;
    end
  end

  // Mover box geometry
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_mover) begin
      m_x_q     <= n_x_q;
      m_y_q     <= n_y_q;
      m_w_q     <= n_w_q;
      m_h_q     <= n_h_q;
      m_solid_q <= n_solid_q;
    end
  end

  // Working velocities: seed, shrink, give up
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      vx_w_q  <= run_vx_q;
      vy_w_q  <= run_vy_q;
      pvx_w_q <= vel_x_i;
      pvy_w_q <= vel_y_i;
    end else if (cmd_i.load_mover) begin
      vx_w_q <= n_vx_q;
      vy_w_q <= n_vy_q;
    end else if (cmd_i.shrink_x) begin
      vx_w_q  <= vx_w_q >>> cmd_i.shamt;
      pvx_w_q <= pvx_w_q >>> cmd_i.shamt;
    end else if (cmd_i.shrink_y) begin
      vy_w_q  <= vy_w_q >>> cmd_i.shamt;
      pvy_w_q <= pvy_w_q >>> cmd_i.shamt;
    end else if (cmd_i.zero_x) begin
      // both boxes stay at their X positions for the Y test
      vx_w_q  <= '0;
      pvx_w_q <= '0;
    end else if (cmd_i.zero_y) begin
      vy_w_q  <= '0;
      pvy_w_q <= '0;
    end
  end

  // Hit flag
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      hit_q <= 1'b0;
    end else if (cmd_i.set_hit) begin
      hit_q <= 1'b1;
    end
  end

  // Architectural mover state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_active_q  <= 1'b0;
      run_vx_q    <= '0;
      run_vy_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load_mover) begin
        m_active_q <= (n_vx_q != '0) || (n_vy_q != '0);
      end else if (cmd_i.out_load && last_item) begin
        m_active_q <= 1'b0;
      end
      if (cmd_i.out_load) begin
        run_vx_q    <= vx_w_q;
        run_vy_q    <= vy_w_q;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_hit_q  <= hit_q;
      out_vx_q   <= vx_w_q;
      out_vy_q   <= vy_w_q;
      out_done_q <= last_item;
    end
  end

  // Shared overlap comparator at the predicted positions
  always_comb begin
    mw = {{(OvlW-SizeW){1'b0}}, m_w_q};
    mh = {{(OvlW-SizeW){1'b0}}, m_h_q};
    nw = {{(OvlW-SizeW){1'b0}}, n_w_q};
    nh = {{(OvlW-SizeW){1'b0}}, n_h_q};
    ax = {{(OvlW-PosW){m_x_q[PosW-1]}}, m_x_q} + {{(OvlW-VelW){vx_w_q[VelW-1]}}, vx_w_q};
    bx = {{(OvlW-PosW){n_x_q[PosW-1]}}, n_x_q} + {{(OvlW-VelW){pvx_w_q[VelW-1]}}, pvx_w_q};
    ay = {{(OvlW-PosW){m_y_q[PosW-1]}}, m_y_q};
    by = {{(OvlW-PosW){n_y_q[PosW-1]}}, n_y_q};
    if (cmd_i.use_y) begin
      ay = ay + {{(OvlW-VelW){vy_w_q[VelW-1]}}, vy_w_q};
      by = by + {{(OvlW-VelW){pvy_w_q[VelW-1]}}, pvy_w_q};
    end
  end

  assign sts_o.ovl = (ax + mw > bx) && (ax < bx + nw) && (ay + mh > by) && (ay < by + nh);

  // Leading exception: mover already moving away on that axis
  assign sts_o.ex_x = (!vx_w_q[VelW-1] && (vx_w_q != '0) && (m_x_q > n_x_q)) ||
                      (vx_w_q[VelW-1] && (m_x_q < n_x_q));
  assign sts_o.ex_y = (!vy_w_q[VelW-1] && (vy_w_q != '0) && (m_y_q > n_y_q)) ||
                      (vy_w_q[VelW-1] && (m_y_q < n_y_q));

  assign sts_o.op         = n_op_q;
  assign sts_o.active     = m_active_q;
  assign sts_o.solid_both = m_solid_q && n_solid_q;
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign hit_o         = out_hit_q;
  assign mover_vel_x_o = out_vx_q;
  assign mover_vel_y_o = out_vy_q;
  assign done_res_o    = out_done_q;

  `ASVR_ASSERT(a_zero_x_clears, (cmd_i.zero_x |=> (vx_w_q == '0 && pvx_w_q == '0)))
  `ASVR_ASSERT(a_last_drops_active, ((cmd_i.out_load && last_item && !cmd_i.load_mover) |=> !m_active_q))
  `ASVR_NEVER(a_load_overwrites_result, (cmd_i.out_load && out_valid_q && out_stall_i))

endmodule

>>> hdl/aabb_sweep_velocity_resolver_top.sv
// Top level of the axis-separated box collision response block
//
//  channel  direction  handshake                  payload
//  in       sink       in_valid_i / in_stall_o     op, pos_x/y, size_w/h, vel_x/y, solid, last_neighbour
//  out      source     out_valid_o / out_stall_i   hit, mover_vel_x/y, done_res
//
//  One item at a time; the next item is taken the cycle after its result enters the output register.
//  Mover load, idle mover and non-solid neighbour: the item goes from dispatch straight to the finish state.
//  Two solid boxes: the single overlap comparator runs one test a cycle,
//  up to four tests on X and four on Y.
//  Reset clears the sequencer, the held mover velocity, the mover-active flag and output valid.
//  A stalled result holds in the output register; a new item is still taken while it waits.
module aabb_sweep_velocity_resolver_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            op_i,
  input  asvr_pkg::pos_t  pos_x_i,
  input  asvr_pkg::pos_t  pos_y_i,
  input  asvr_pkg::size_t size_w_i,
  input  asvr_pkg::size_t size_h_i,
  input  asvr_pkg::vel_t  vel_x_i,
  input  asvr_pkg::vel_t  vel_y_i,
  input  logic            solid_i,
  input  logic            last_neighbour_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            hit_o,
  output asvr_pkg::vel_t  mover_vel_x_o,
  output asvr_pkg::vel_t  mover_vel_y_o,
  output logic            done_res_o
);
  import asvr_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // Sequencer
  asvr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath
  asvr_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .op_i             (op_i),
    .pos_x_i          (pos_x_i),
    .pos_y_i          (pos_y_i),
    .size_w_i         (size_w_i),
    .size_h_i         (size_h_i),
    .vel_x_i          (vel_x_i),
    .vel_y_i          (vel_y_i),
    .solid_i          (solid_i),
    .last_neighbour_i (last_neighbour_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .hit_o            (hit_o),
    .mover_vel_x_o    (mover_vel_x_o),
    .mover_vel_y_o    (mover_vel_y_o),
    .done_res_o       (done_res_o)
  );

endmodule

>>> bench/tb_aabb_sweep_velocity_resolver_top.sv
// Self-checking testbench for the box collision response block, with its own velocity predictor
`timescale 1ns / 1ps

module tb_aabb_sweep_velocity_resolver_top;
  import asvr_pkg::*;

  localparam int TimeoutNs  = 2_000_000;
  localparam int ShowLimit  = 10;
  localparam int HoldCycles = 400;

  // One input item as offered on the input channel
  typedef struct {
    op_e   op;
    pos_t  px;
    pos_t  py;
    size_t w;
    size_t h;
    vel_t  vx;
    vel_t  vy;
    logic  solid;
    logic  last;
  } box_item_t;

  // One velocity report as expected on the output channel
  typedef struct {
    logic hit;
    vel_t vx;
    vel_t vy;
    logic done;
  } vel_report_t;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  in_valid_i = 1'b0;
  logic  in_stall_o;
  logic  op_i = 1'b0;
  pos_t  pos_x_i = '0;
  pos_t  pos_y_i = '0;
  size_t size_w_i = '0;
  size_t size_h_i = '0;
  vel_t  vel_x_i = '0;
  vel_t  vel_y_i = '0;
  logic  solid_i = 1'b0;
  logic  last_neighbour_i = 1'b0;
  logic  out_valid_o;
  logic  out_stall_i = 1'b0;
  logic  hit_o;
  vel_t  mover_vel_x_o;
  vel_t  mover_vel_y_o;
  logic  done_res_o;

  // Predictor copy of the mover registers
  longint held_x, held_y, held_w, held_h, held_vx, held_vy;
  bit     held_solid, held_active;

  vel_report_t predicted_reports[$];
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  bit          hold_on = 1'b0;
  event        hold_go;

  aabb_sweep_velocity_resolver_top u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .op_i             (op_i),
    .pos_x_i          (pos_x_i),
    .pos_y_i          (pos_y_i),
    .size_w_i         (size_w_i),
    .size_h_i         (size_h_i),
    .vel_x_i          (vel_x_i),
    .vel_y_i          (vel_y_i),
    .solid_i          (solid_i),
    .last_neighbour_i (last_neighbour_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .hit_o            (hit_o),
    .mover_vel_x_o    (mover_vel_x_o),
    .mover_vel_y_o    (mover_vel_y_o),
    .done_res_o       (done_res_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Exact box overlap test on wide integers
  function automatic bit boxes_meet(longint xa, longint ya, longint wa, longint ha,
                                    longint xb, longint yb, longint wb, longint hb);
    return (xa + wa > xb) && (xa < xb + wb) && (ya + ha > yb) && (ya < yb + hb);
  endfunction

  // Advance the mover state by one item and work out its velocity report
  function automatic vel_report_t resolve_item(box_item_t it);
    longint      px, py, pw, ph, pvx, pvy, vx, vy, ax, ay, bx, by;
    bit          away, ok;
    int          k;
    vel_report_t r;
    px = it.px;
    py = it.py;
    pw = it.w;
    ph = it.h;
    pvx = it.vx;
    pvy = it.vy;
    r.hit = 1'b0;
    r.done = 1'b0;
    if (it.op == OP_LOAD_MOVER) begin
      held_x = px;
      held_y = py;
      held_w = pw;
      held_h = ph;
      held_vx = pvx;
      held_vy = pvy;
      held_solid = it.solid;
      held_active = (pvx != 0) || (pvy != 0);
    end else if (!held_active) begin
      r.done = it.last;
    end else begin
      vx = held_vx;
      vy = held_vy;
      if (!held_solid || !it.solid) begin
        // Report only: overlap at the predicted positions
        r.hit = boxes_meet(held_x + vx, held_y + vy, held_w, held_h,
                           px + pvx, py + pvy, pw, ph);
      end else begin
        // X axis, skipped when the mover already leaves the neighbour
        ax = held_x + vx;
        ay = held_y;
        bx = px + pvx;
        by = py;
        away = (vx > 0 && held_x > px) || (vx < 0 && held_x < px);
        if (!away && boxes_meet(ax, ay, held_w, held_h, bx, by, pw, ph)) begin
          r.hit = 1'b1;
          ok = 1'b0;
          for (k = 1; k <= 3 && !ok; k++) begin
            vx = vx >>> k;
            pvx = pvx >>> k;
            ax = held_x + vx;
            bx = px + pvx;
            ok = !boxes_meet(ax, ay, held_w, held_h, bx, by, pw, ph);
          end
          if (!ok) begin
            vx = 0;
            ax = held_x;
            bx = px;
          end
        end
        // Y axis, tested at the X positions just settled
        ay = held_y + vy;
        by = py + pvy;
        away = (vy > 0 && held_y > py) || (vy < 0 && held_y < py);
        if (!away && boxes_meet(ax, ay, held_w, held_h, bx, by, pw, ph)) begin
          r.hit = 1'b1;
          ok = 1'b0;
          for (k = 1; k <= 3 && !ok; k++) begin
            vy = vy >>> k;
            pvy = pvy >>> k;
            ay = held_y + vy;
            by = py + pvy;
            ok = !boxes_meet(ax, ay, held_w, held_h, bx, by, pw, ph);
          end
          if (!ok) vy = 0;
        end
      end
      held_vx = vx;
      held_vy = vy;
      r.done = it.last;
      if (it.last) held_active = 1'b0;
    end
    r.vx = held_vx[15:0];
    r.vy = held_vy[15:0];
    return r;
  endfunction

  // Offer one item after a random idle gap; hold it until the transfer, then predict
  task automatic send_item(op_e op, pos_t px, pos_t py, size_t w, size_t h,
                           vel_t vx, vel_t vy, logic solid, logic last);
    int        gap;
    box_item_t it;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    op_i <= op;
    pos_x_i <= px;
    pos_y_i <= py;
    size_w_i <= w;
    size_h_i <= h;
    vel_x_i <= vx;
    vel_y_i <= vy;
    solid_i <= solid;
    last_neighbour_i <= last;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    it = '{op, px, py, w, h, vx, vy, solid, last};
    predicted_reports = {predicted_reports, resolve_item(it)};
  endtask

  function automatic size_t pick_size();
    if ($urandom_range(15) == 0) return size_t'($urandom);
    return size_t'($urandom_range(3072, 64));
  endfunction

  function automatic vel_t pick_vel();
    case ($urandom_range(7))
      0: return '0;
      1: return vel_t'($urandom);
      default: return vel_t'(int'($urandom_range(2048)) - 1024);
    endcase
  endfunction

  // One mover followed by neighbours placed around it; now and then the last flag is dropped
  task automatic send_frame(int n_nb);
    pos_t  mx, my;
    size_t mw, mh;
    int    span_x, span_y, i;
    bit    broken;
    mx = pos_t'($urandom);
    my = pos_t'($urandom);
    mw = pick_size();
    mh = pick_size();
    span_x = int'(mw) + 2048;
    span_y = int'(mh) + 2048;
    broken = ($urandom_range(9) == 0);
    send_item(OP_LOAD_MOVER, mx, my, mw, mh, pick_vel(), pick_vel(),
              $urandom_range(9) != 0, 1'($urandom_range(1)));
    for (i = 0; i < n_nb; i++) begin
      send_item(OP_NEIGHBOUR,
                pos_t'(int'(mx) + int'($urandom_range(2 * span_x)) - span_x),
                pos_t'(int'(my) + int'($urandom_range(2 * span_y)) - span_y),
                pick_size(), pick_size(), pick_vel(), pick_vel(),
                $urandom_range(7) != 0, (i == n_nb - 1) && !broken);
    end
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    stall_pct = recv_pct;
  endtask

  // Neighbours with no mover loaded, and a mover at rest
  task automatic test_no_mover();
    send_item(OP_NEIGHBOUR, 0, 0, 256, 256, 0, 0, 1'b1, 1'b0);
    send_item(OP_NEIGHBOUR, 0, 0, 256, 256, 0, 0, 1'b1, 1'b1);
    send_item(OP_LOAD_MOVER, 0, 0, 1024, 1024, 0, 0, 1'b1, 1'b0);
    send_item(OP_NEIGHBOUR, 0, 0, 1024, 1024, 0, 0, 1'b1, 1'b1);
  endtask

  // Shrink steps, axis give-up, leading exception and report-only pairs
  task automatic test_shrink_and_give_up();
    // X settles at an eighth, then a full overlap gives up X and hits on Y
    send_item(OP_LOAD_MOVER, 0, 0, 1024, 1024, 512, 0, 1'b1, 1'b0);
    send_item(OP_NEIGHBOUR, 1200, 0, 1024, 1024, 0, 0, 1'b1, 1'b0);
    send_item(OP_NEIGHBOUR, 0, 0, 1024, 1024, 0, 0, 1'b1, 1'b1);
    send_item(OP_NEIGHBOUR, 0, 0, 1024, 1024, 0, 0, 1'b1, 1'b0);
    // Y settles with both boxes moving towards each other
    send_item(OP_LOAD_MOVER, 0, 0, 1024, 1024, 0, 1024, 1'b1, 1'b0);
    send_item(OP_NEIGHBOUR, 0, 1500, 1024, 1024, 0, -512, 1'b1, 1'b1);
    // Small negative velocity: shifts round down and never reach zero
    send_item(OP_LOAD_MOVER, 0, 0, 1024, 1024, -3, 0, 1'b1, 1'b0);
    send_item(OP_NEIGHBOUR, -512, 0, 1024, 1024, 0, 0, 1'b1, 1'b1);
    // Mover already leaving the neighbour, both directions
    send_item(OP_LOAD_MOVER, 0, 0, 1024, 1024, -256, 0, 1'b1, 1'b0);
    send_item(OP_NEIGHBOUR, 512, 0, 1024, 1024, 0, 0, 1'b1, 1'b1);
    send_item(OP_LOAD_MOVER, 2048, 0, 1024, 1024, 256, 0, 1'b1, 1'b0);
    send_item(OP_NEIGHBOUR, 1536, 0, 1024, 1024, 0, 0, 1'b1, 1'b1);
    // Non-solid mover: edge contact is no hit, real overlap is
    send_item(OP_LOAD_MOVER, 0, 0, 256, 256, 256, 256, 1'b0, 1'b0);
    send_item(OP_NEIGHBOUR, 512, 512, 256, 256, 0, 0, 1'b1, 1'b0);
    send_item(OP_NEIGHBOUR, 400, 400, 256, 256, 0, 0, 1'b1, 1'b1);
    // Non-solid neighbour against a solid mover
    send_item(OP_LOAD_MOVER, 0, 0, 256, 256, 256, 0, 1'b1, 1'b0);
    send_item(OP_NEIGHBOUR, 300, 0, 256, 256, 0, 0, 1'b0, 1'b1);
  endtask

  // Field extremes on positions, sizes and velocities
  task automatic test_field_extremes();
    send_item(OP_LOAD_MOVER, 24'sh7FFFFF, -24'sh800000, 22'h3FFFFF, 22'h3FFFFF,
              -16'sh8000, 16'sh7FFF, 1'b1, 1'b0);
    send_item(OP_NEIGHBOUR, -24'sh800000, 24'sh7FFFFF, 22'h3FFFFF, 22'h0,
              16'sh7FFF, -16'sh8000, 1'b1, 1'b0);
    send_item(OP_NEIGHBOUR, 24'sh7FFFFF, -24'sh800000, 22'h0, 22'h3FFFFF,
              -16'sh8000, -16'sh8000, 1'b1, 1'b1);
    send_item(OP_LOAD_MOVER, -24'sh800000, 24'sh7FFFFF, 22'h0, 22'h0,
              16'sh7FFF, -16'sh8000, 1'b0, 1'b1);
    send_item(OP_NEIGHBOUR, -24'sh800000, 24'sh7FFFF0, 22'h3FFFFF, 22'h3FFFFF,
              16'sh7FFF, 16'sh7FFF, 1'b1, 1'b1);
  endtask

  // Mostly well-formed frames with random content, some raw noise items
  task automatic test_random_frames(int n_items);
    int sent, n_nb;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(7) == 0) begin
        send_item(op_e'($urandom_range(1)), pos_t'($urandom), pos_t'($urandom),
                  size_t'($urandom), size_t'($urandom), vel_t'($urandom),
                  vel_t'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)));
        sent++;
      end else begin
        n_nb = $urandom_range(6, 1);
        send_frame(n_nb);
        sent += n_nb + 1;
      end
    end
  endtask

  // Hold the output off for a long stretch while items keep coming
  task automatic test_output_hold();
    -> hold_go;
    send_frame(24);
  endtask

  // Count out the long output hold in cycles
  initial begin : hold_counter
    forever begin
      @(hold_go);
      hold_on <= 1'b1;
      repeat (HoldCycles) @(posedge clk_i);
      hold_on <= 1'b0;
    end
  end

  // Drive the output stall: long hold when asked, random stalls otherwise
  always @(posedge clk_i) begin
    if (hold_on) begin
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Compare each transfer on the output with the oldest prediction
  always @(posedge clk_i) begin : check_reports
    vel_report_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (predicted_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= ShowLimit)
          $display("unexpected report: hit %0b vx %0d vy %0d done %0b",
                   hit_o, mover_vel_x_o, mover_vel_y_o, done_res_o);
      end else begin
        want = predicted_reports.pop_front();
        if (want.hit !== hit_o || want.vx !== mover_vel_x_o ||
            want.vy !== mover_vel_y_o || want.done !== done_res_o) begin
          mismatches++;
          if (mismatches <= ShowLimit)
            $display("report mismatch (exp/got): hit %0b/%0b vx %0d/%0d vy %0d/%0d done %0b/%0b",
                     want.hit, hit_o, want.vx, mover_vel_x_o, want.vy, mover_vel_y_o,
                     want.done, done_res_o);
        end
      end
    end
  end

  initial begin : run_tests
    int waited;
    held_x = 0;
    held_y = 0;
    held_w = 0;
    held_h = 0;
    held_vx = 0;
    held_vy = 0;
    held_solid = 1'b0;
    held_active = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_idling(0, 0);
    test_no_mover();
    test_shrink_and_give_up();
    test_field_extremes();
    test_random_frames(400);
    set_idling(59, 0);
    test_random_frames(400);
    set_idling(0, 59);
    test_random_frames(400);
    set_idling(20, 20);
    test_random_frames(400);
    set_idling(0, 0);
    test_output_hold();
    in_valid_i <= 1'b0;

    // Drain outstanding reports, then allow for the block's latency
    waited = 0;
    while (predicted_reports.size() > 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (30) @(posedge clk_i);
    if (predicted_reports.size() > 0) begin
      $display("%0d predicted reports never arrived", predicted_reports.size());
    end

    if (mismatches == 0 && predicted_reports.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Hard stop in case the block hangs
  initial begin
    #(TimeoutNs);
    $display("Regression FAIL");
    $finish;
  end

endmodule
